>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication at every rising clk edge, skipped while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/itp_pkg.sv
// Package with types and constants of the integer text parser.
package itp_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEX    = 3'd3,
    PH_QUOTE  = 3'd4,
    PH_DEC    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  localparam logic [1:0] FORM_DEC  = 2'd0;
  localparam logic [1:0] FORM_HEX  = 2'd1;
  localparam logic [1:0] FORM_CHAR = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

endpackage

>>> rtl/itp_stream_if.sv
// Stream interfaces for text bytes and parsed results.
interface itp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface itp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  form;

  modport source (output valid, output value, output form, input ready);
  modport sink   (input valid, input value, input form, output ready);
endinterface

>>> rtl/integer_text_parser.sv
// Streaming integer text parser: top level.
//
// Usage: feed the bytes of NUL-terminated strings on char_in, one byte per
// transfer. For each string one result comes out on result_out: value is the
// parsed signed 32-bit integer (wrapped modulo 2^32) and form tells decimal,
// hex ("0x"/"0X" prefix) or character literal (leading quote). A leading '-'
// negates the result. The byte that ends the number releases the result; the
// rest of the string up to NUL is swallowed without results.
//
// Throughput: one byte per cycle, sustained, as long as result_out drains.
// A byte accepted into the byte register is parsed as it leaves it, and its
// result, if any, is loaded into the result register at the same edge. Between
// the two lies the parse step: one shift-add (x10 or x16) of the accumulator.
//
// Reset: rst clears the byte register, the result register and the parser
// state to start of string. When the receiver stalls, the result is held and
// one more byte is buffered in the byte register; then char_in.ready drops.
module integer_text_parser
  import itp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  itp_byte_if.sink      char_in,
  itp_result_if.source  result_out
);

`include "assert_macros.svh"

  // byte register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parser state
  phase_t      phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] accumulator, accumulator_next;

  // result register
  logic        out_valid;
  logic [31:0] out_value;
  logic [1:0]  out_form;

  // step decode
  logic        s1_adv;
  logic        s1_fire;
  logic        emit;
  logic [31:0] emit_mag;
  logic [1:0]  emit_form;
  logic [31:0] emit_value;
  logic        c_dec;
  logic        c_hex;
  logic [3:0]  c_nib;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;
  logic [31:0] lit;

  // Advance the byte register whenever the result register can take a result.
  assign s1_adv       = !out_valid || result_out.ready;
  assign s1_fire      = s1_valid && s1_adv;
  assign char_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_byte <= char_in.char_byte;
    end
  end

  // Character classes and digit value.
  always_comb begin
    c_dec = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
    c_hex = 1'b1;
    c_nib = 4'd0;
    if (c_dec) begin
      c_nib = 4'(s1_byte - CH_ZERO);
    end else if ((s1_byte >= CH_LO_A) && (s1_byte <= CH_LO_F)) begin
      c_nib = 4'(s1_byte - CH_LO_A + 8'd10);
    end else if ((s1_byte >= CH_UP_A) && (s1_byte <= CH_UP_F)) begin
      c_nib = 4'(s1_byte - CH_UP_A + 8'd10);
    end else begin
      c_hex = 1'b0;
    end
  end

  // Accumulate: x10 as (x8 + x2), x16 as a shift.
  assign acc_dec = (accumulator << 3) + (accumulator << 1) + {28'd0, c_nib};
  assign acc_hex = {accumulator[27:0], c_nib};
  assign lit     = {{24{s1_byte[7]}}, s1_byte};

  // Next state.
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    case (phase)
      PH_START, PH_SIGNED: begin
        if (phase == PH_START && s1_byte == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_SIGNED;
        end else begin
          if (phase == PH_START) negative_next = 1'b0;
          accumulator_next = 32'd0;
          if (s1_byte == CH_ZERO) begin
            phase_next = PH_ZERO;
          end else if (s1_byte == CH_QUOTE) begin
            phase_next = PH_QUOTE;
          end else if (c_dec) begin
            accumulator_next = {28'd0, c_nib};
            phase_next       = PH_DEC;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      PH_ZERO, PH_DEC: begin
        if (phase == PH_ZERO && (s1_byte == CH_LO_X || s1_byte == CH_UP_X)) begin
          accumulator_next = 32'd0;
          phase_next       = PH_HEX;
        end else if (c_dec) begin
          accumulator_next = acc_dec;
          phase_next       = PH_DEC;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_HEX: begin
        if (c_hex) begin
          accumulator_next = acc_hex;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_QUOTE: phase_next = PH_DONE;
      default:  phase_next = PH_DONE;
    endcase
    // NUL always rearms: it either ends the number or closes the trailer.
    if (s1_byte == CH_NUL) begin
      phase_next       = PH_START;
      negative_next    = 1'b0;
      accumulator_next = 32'd0;
    end
  end

  // Result decode.
  always_comb begin
    emit      = 1'b0;
    emit_mag  = accumulator;
    emit_form = FORM_DEC;
    case (phase)
      PH_START: begin
        emit     = (s1_byte != CH_MINUS) && !c_dec && (s1_byte != CH_QUOTE);
        emit_mag = 32'd0;
      end
      PH_SIGNED: begin
        emit     = !c_dec && (s1_byte != CH_QUOTE);
        emit_mag = 32'd0;
      end
      PH_ZERO: begin
        emit = !c_dec && (s1_byte != CH_LO_X) && (s1_byte != CH_UP_X);
      end
      PH_DEC: begin
        emit = !c_dec;
      end
      PH_HEX: begin
        emit      = !c_hex;
        emit_form = FORM_HEX;
      end
      PH_QUOTE: begin
        emit      = 1'b1;
        emit_mag  = lit;
        emit_form = FORM_CHAR;
      end
      default: emit = 1'b0;
    endcase
  end

  assign emit_value = negative ? (32'd0 - emit_mag) : emit_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      negative    <= 1'b0;
      accumulator <= 32'd0;
    end else if (s1_fire) begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  // Result register: load on a result, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_value <= emit_value;
      out_form  <= emit_form;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.value = out_value;
  assign result_out.form  = out_form;

  // A fresh result always comes from a parsed byte.
  `ASSERT_IMPL(a_result_from_byte, out_valid && !$past(out_valid) && !$past(rst),
               $past(s1_valid), "result appeared without a parsed byte")
  // Start of string carries no sign and an empty accumulator.
  `ASSERT_IMPL(a_start_clean, phase == PH_START,
               !negative && accumulator == 32'd0, "dirty state at start of string")
  // A full byte register behind a stalled result blocks new bytes.
  `ASSERT_IMPL(a_stall_blocks, s1_valid && out_valid && !result_out.ready,
               !char_in.ready, "byte accepted while pipeline stalled")

endmodule

>>> verif/tb_integer_text_parser.sv
// Testbench for the streaming integer text parser.
module tb_integer_text_parser;
  import itp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  // Settling time after the drain, covering a byte still in the byte register
  // and a result still in the result register.
  localparam int TAIL_CYCLES    = 4;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int LONG_HOLD      = 150;

  localparam logic [31:0] DEC_BASE = 32'd10;
  localparam logic [4:0]  NOT_HEX  = 5'd16;

  typedef struct {
    logic signed [31:0] value;
    logic        [1:0]  form;
  } parsed_number_t;

  logic clk;
  logic rst;

  itp_byte_if   char_in ();
  itp_result_if result_out ();

  integer_text_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .result_out (result_out)
  );

  // Numbers the parser owes us, oldest first.
  parsed_number_t pending_numbers[$];

  // Our own copy of the parser state.
  phase_t      prs_phase;
  logic        prs_negative;
  logic [31:0] prs_acc;

  int mismatch_count;
  int parsed_bytes;     // bytes handed to the parser
  int sender_idle_pct;
  int sink_stall_pct;
  int hold_cycles;      // long receiver hold-off, counted down by the receiver

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: mirror the parser one byte at a time and queue each number.
  // ---------------------------------------------------------------------------
  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (is_dec_digit(c)) return 5'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
    return NOT_HEX;
  endfunction

  function void rearm_parser();
    prs_phase    = PH_START;
    prs_negative = 1'b0;
    prs_acc      = '0;
  endfunction

  // Close the number: apply the sign (wrapping), queue it, and either rearm
  // on NUL or skip the rest of the string.
  function void close_number(input logic [31:0] mag, input logic [1:0] form,
                             input logic [7:0] c);
    parsed_number_t num;
    num.value = prs_negative ? (32'd0 - mag) : mag;
    num.form  = form;
    pending_numbers.push_back(num);
    if (c == CH_NUL) rearm_parser();
    else prs_phase = PH_DONE;
  endfunction

  function void start_body(input logic [7:0] c);
    prs_acc = '0;
    if (c == CH_ZERO) begin
      prs_phase = PH_ZERO;
    end else if (c == CH_QUOTE) begin
      prs_phase = PH_QUOTE;
    end else if (is_dec_digit(c)) begin
      prs_acc   = 32'(c - CH_ZERO);
      prs_phase = PH_DEC;
    end else begin
      close_number('0, FORM_DEC, c);
    end
  endfunction

  function void add_dec_digit(input logic [7:0] c);
    if (is_dec_digit(c)) begin
      prs_acc   = prs_acc * DEC_BASE + 32'(c - CH_ZERO);
      prs_phase = PH_DEC;
    end else begin
      close_number(prs_acc, FORM_DEC, c);
    end
  endfunction

  function void parse_byte(input logic [7:0] c);
    logic [4:0] h;
    case (prs_phase)
      PH_START: begin
        if (c == CH_MINUS) begin
          prs_negative = 1'b1;
          prs_phase    = PH_SIGNED;
        end else begin
          prs_negative = 1'b0;
          start_body(c);
        end
      end
      PH_SIGNED: start_body(c);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          prs_acc   = '0;
          prs_phase = PH_HEX;
        end else begin
          add_dec_digit(c);
        end
      end
      PH_HEX: begin
        h = hex_digit_value(c);
        if (h != NOT_HEX) prs_acc = {prs_acc[27:0], 4'b0000} + 32'(h);
        else close_number(prs_acc, FORM_HEX, c);
      end
      // The literal byte is sign-extended as a signed char.
      PH_QUOTE: close_number({{24{c[7]}}, c}, FORM_CHAR, c);
      PH_DEC:   add_dec_digit(c);
      default: begin
        if (c == CH_NUL) rearm_parser();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive at the falling edge, take the transfer at the rising edge.
  // valid stays high after a transfer; the next call either replaces the
  // byte or first drops valid while the sender idles, never both at the same falling edge.
  // ---------------------------------------------------------------------------
  task send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      char_in.valid <= 1'b0;
      @(negedge clk);
    end
    char_in.valid     <= 1'b1;
    char_in.char_byte <= b;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    parsed_bytes++;
    parse_byte(b);
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid and hold off until every owed number has come out, then let
  // the pipeline settle.
  task wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    char_in.valid <= 1'b0;
    while (pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when hold_cycles is loaded.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_out.ready <= 1'b0;
      hold_cycles--;
    end else begin
      result_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Checker: every result transfer must match the oldest owed number.
  always @(posedge clk) begin
    parsed_number_t exp_num;
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_numbers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d form %0d",
                 $time, result_out.value, result_out.form);
        mismatch_count++;
      end else begin
        exp_num = pending_numbers.pop_front();
        if (result_out.value !== exp_num.value) begin
          $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                   exp_num.value, result_out.value);
          mismatch_count++;
        end
        if (result_out.form !== exp_num.form) begin
          $display("%0t: form mismatch: expected %0d, actual %0d", $time,
                   exp_num.form, result_out.form);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random strings: mostly well-formed numbers with random content, the rest
  // noise. Endings mix a bare NUL with random trailing bytes and then a NUL.
  // ---------------------------------------------------------------------------
  task send_random_string();
    string hex_chars;
    int    n_digits;
    int    n_junk;
    hex_chars = "0123456789abcdefABCDEF";
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(3) == 0) send_byte(CH_MINUS);
      case ($urandom_range(2))
        0: begin
          // mostly short; now and then long enough to wrap past 2^32
          n_digits = ($urandom_range(9) == 0) ? $urandom_range(11, 20)
                                              : $urandom_range(1, 10);
          repeat (n_digits) send_byte(CH_ZERO + 8'($urandom_range(9)));
        end
        1: begin
          send_byte(CH_ZERO);
          send_byte($urandom_range(1) ? CH_LO_X : CH_UP_X);
          n_digits = $urandom_range(0, 10);
          repeat (n_digits) send_byte(hex_chars[$urandom_range(21)]);
        end
        default: begin
          send_byte(CH_QUOTE);
          send_byte(8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(1) == 0) begin
        send_byte(CH_NUL);
      end else begin
        n_junk = $urandom_range(1, 4);
        repeat (n_junk) send_byte(8'($urandom_range(255)));
        send_byte(CH_NUL);
      end
    end else begin
      n_junk = $urandom_range(1, 6);
      repeat (n_junk) send_byte(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) send_byte(CH_NUL);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty string, then a sign with nothing after it.
  task test_empty_strings();
    send_byte(CH_NUL);
    send_byte(CH_MINUS);
    send_byte(CH_NUL);
    wait_drained();
  endtask

  // Lone zero stays decimal; bare hex prefix; mixed-case hex closed by a
  // stop byte, with a high trailing byte swallowed before NUL.
  task test_decimal_and_hex();
    send_byte(CH_ZERO);
    send_byte(CH_NUL);
    send_text("0xg");
    send_byte(CH_NUL);
    send_text("-0XfF ");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    wait_drained();
  endtask

  // Quote then NUL; negated literal of the most negative char.
  task test_char_literal();
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    send_byte(CH_MINUS);
    send_byte(CH_QUOTE);
    send_byte(8'h80);
    send_byte(CH_NUL);
    wait_drained();
  endtask

  task test_random_strings(input int idle_pct, input int stall_pct, input int n_items);
    int target;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    target = parsed_bytes + n_items;
    while (parsed_bytes < target) send_random_string();
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // short numbers, so the parser fills up and stalls its input.
  task test_output_backpressure();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_cycles     = LONG_HOLD;
    repeat (12) begin
      if ($urandom_range(1)) send_byte(CH_MINUS);
      send_byte(CH_ZERO + 8'($urandom_range(9)));
      send_byte(CH_NUL);
    end
    wait_drained();
  endtask

  initial begin
    int waited;
    clk               = 1'b0;
    rst               = 1'b1;
    char_in.valid     = 1'b0;
    char_in.char_byte = '0;
    result_out.ready  = 1'b0;
    mismatch_count    = 0;
    parsed_bytes      = 0;
    sender_idle_pct   = 0;
    sink_stall_pct    = 0;
    hold_cycles       = 0;
    rearm_parser();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_strings();
    test_decimal_and_hex();
    test_char_literal();
    test_random_strings(0, 0, 100);
    test_random_strings(50, 0, 100);
    test_random_strings(0, 50, 100);
    test_random_strings(6, 6, 100);
    test_output_backpressure();

    // Wait out anything still owed, bounded, then settle.
    waited = 0;
    while (pending_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_numbers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               pending_numbers.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("[integer_text_parser] OK");
    end else begin
      $display("[integer_text_parser] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout", $time);
    $display("[integer_text_parser] ERROR");
    $finish;
  end

endmodule
